@@ sv/slfs_pkg.sv @@
// shared types, codes and constants of the serpentine frame scaler
package slfs_pkg;

  localparam int DefRows   = 5;
  localparam int DefCols   = 5;
  localparam int PosW      = 8;
  localparam int ColorW    = 24;
  localparam int PctW      = 7;

  localparam logic [PctW-1:0] BrightReset = 7'd30;
  localparam logic [PctW-1:0] PctMax      = 7'd100;

  // floor(x / 100) as (x * DivMul) >> DivShift, exact for x up to 255 * 100
  localparam logic [12:0] DivMul   = 13'd5243;
  localparam int          DivShift = 19;

  typedef enum logic [1:0] {
    CMD_WR_RC       = 2'd0,
    CMD_WR_BTN      = 2'd1,
    CMD_SHOW        = 2'd2,
    CMD_SHOW_FORCED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    QK_WRITE       = 2'd0,
    QK_SHOW        = 2'd1,
    QK_SHOW_FORCED = 2'd2
  } qkind_t;

  typedef struct packed {
    qkind_t            kind;
    logic [PosW-1:0]   pos;
    logic [ColorW-1:0] color;
  } qent_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } bk_state_t;

  typedef struct packed {
    logic scanning;
    logic changed;
  } bk_status_t;

endpackage

@@ sv/slfs_front.sv @@
// front end: accepts items, maps writes to strip positions, drops out-of-range writes
module slfs_front import slfs_pkg::*; #(
  parameter int MATRIX_ROWS = DefRows,
  parameter int MATRIX_COLS = DefCols
) (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [2:0]  row,
  input  logic [2:0]  col,
  input  logic [4:0]  button,
  input  logic [23:0] color,
  input  logic        q_full,
  output logic        q_push,
  output qent_t       q_ent
);

  localparam int Pixels = MATRIX_ROWS * MATRIX_COLS;

  logic [4:0] btn_row [32];
  logic [4:0] btn_col [32];

  // button number split into row and column, worked out at elaboration
  for (genvar b = 0; b < 32; b++) begin : g_btn
    localparam int BtnRow = b / MATRIX_COLS;
    localparam int BtnCol = b % MATRIX_COLS;
    assign btn_row[b] = 5'(BtnRow);
    assign btn_col[b] = 5'(BtnCol);
  end

  cmd_t       cmd_code;
  logic [4:0] sel_row;
  logic [4:0] sel_col;
  logic       in_range;
  logic [9:0] row_base;
  logic [9:0] pos_full;

  always_comb begin
    cmd_code = cmd_t'(cmd);
    sel_row  = '0;
    sel_col  = '0;
    in_range = 1'b1;
    q_ent.kind = QK_WRITE;
    unique case (cmd_code)
      CMD_WR_RC: begin
        sel_row  = {2'b00, row};
        sel_col  = {2'b00, col};
        in_range = (32'(row) < MATRIX_ROWS) && (32'(col) < MATRIX_COLS);
      end
      CMD_WR_BTN: begin
        sel_row  = btn_row[button];
        sel_col  = btn_col[button];
        in_range = 32'(button) < Pixels;
      end
      CMD_SHOW:        q_ent.kind = QK_SHOW;
      CMD_SHOW_FORCED: q_ent.kind = QK_SHOW_FORCED;
      default:         q_ent.kind = QK_SHOW;
    endcase

    // odd rows run right to left along the strip
    row_base = 10'(sel_row) * 10'(MATRIX_COLS);
    if (sel_row[0]) begin
      pos_full = row_base + 10'(MATRIX_COLS) - 10'(sel_col) - 10'd1;
    end else begin
      pos_full = row_base + 10'(sel_col);
    end
    q_ent.pos   = pos_full[PosW-1:0];
    q_ent.color = color;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && in_range;

endmodule

@@ sv/slfs_queue.sv @@
// two-entry queue between the front end and the scan engine
module slfs_queue import slfs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_ent,
  input  logic  pop,
  output qent_t pop_ent,
  output logic  full,
  output logic  not_empty
);

  qent_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

  assign pop_ent   = slots[rd_ptr];
  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;

endmodule

@@ sv/slfs_back.sv @@
// scan engine: frame store, changed flag and the scaling pipeline to the output register
module slfs_back import slfs_pkg::*; #(
  parameter int MATRIX_ROWS = DefRows,
  parameter int MATRIX_COLS = DefCols
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_not_empty,
  input  qent_t           q_ent,
  output logic            q_pop,
  input  logic [PctW-1:0] pct_in,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [4:0]      strip_index,
  output logic [7:0]      red_out,
  output logic [7:0]      green_out,
  output logic [7:0]      blue_out,
  output logic            last_pixel,
  output bk_status_t      status
);

  localparam int Pixels = MATRIX_ROWS * MATRIX_COLS;
  localparam int AddrW  = (Pixels > 1) ? $clog2(Pixels) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Pixels - 1);

  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(DivMul);
    return p[DivShift+7:DivShift];
  endfunction

  bk_state_t       state;
  bk_state_t       state_next;
  logic            changed;
  logic [AddrW-1:0] scan_cnt;

  logic [ColorW-1:0] mem [Pixels];
  logic [Pixels-1:0] mem_ok;

  logic advance;
  logic issue;
  logic mem_we;
  logic show_go;
  logic scan_start;
  logic [AddrW-1:0] wr_addr;

  logic              s1_valid;
  logic [ColorW-1:0] rd_data;
  logic              rd_ok;
  logic [AddrW-1:0]  s1_idx;
  logic              s1_last;

  logic              s2_valid;
  logic [14:0]       s2_red;
  logic [14:0]       s2_green;
  logic [14:0]       s2_blue;
  logic [AddrW-1:0]  s2_idx;
  logic              s2_last;

  logic [ColorW-1:0] pixel;
  logic [PctW-1:0]   pct;

  // the whole pipe moves only when the output register can take a new value
  assign advance = !out_valid || !out_stall;
  assign show_go = (q_ent.kind == QK_SHOW_FORCED) || ((q_ent.kind == QK_SHOW) && changed);
  assign wr_addr = q_ent.pos[AddrW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_not_empty && show_go) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (advance && (scan_cnt == LastAddr)) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    issue      = 1'b0;
    mem_we     = 1'b0;
    scan_start = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop      = q_not_empty;
        mem_we     = q_not_empty && (q_ent.kind == QK_WRITE);
        scan_start = q_not_empty && show_go;
      end
      BK_SCAN: issue = advance;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      changed   <= 1'b0;
      scan_cnt  <= '0;
      mem_ok    <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mem_we) begin
        changed         <= 1'b1;
        mem_ok[wr_addr] <= 1'b1;
      end else if (scan_start) begin
        changed <= 1'b0;
      end
      if (scan_start) begin
        scan_cnt <= '0;
      end else if (issue) begin
        scan_cnt <= scan_cnt + AddrW'(1);
      end
      if (advance) begin
        s1_valid  <= issue;
        s2_valid  <= s1_valid;
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_ent.color;
    end
    if (advance) begin
      rd_data <= mem[scan_cnt];
      rd_ok   <= mem_ok[scan_cnt];
      s1_idx  <= scan_cnt;
      s1_last <= scan_cnt == LastAddr;
    end
  end

  always_comb begin
    pixel = rd_ok ? rd_data : '0;
    pct   = (pct_in > PctMax) ? PctMax : pct_in;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_red      <= 15'(pixel[23:16]) * 15'(pct);
      s2_green    <= 15'(pixel[15:8]) * 15'(pct);
      s2_blue     <= 15'(pixel[7:0]) * 15'(pct);
      s2_idx      <= s1_idx;
      s2_last     <= s1_last;
      red_out     <= div100(s2_red);
      green_out   <= div100(s2_green);
      blue_out    <= div100(s2_blue);
      strip_index <= 5'(s2_idx);
      last_pixel  <= s2_last;
    end
  end

  assign status.scanning = state == BK_SCAN;
  assign status.changed  = changed;

endmodule

@@ sv/serpentine_led_frame_scaler_unit.sv @@
// top level of the serpentine led frame scaler
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    cmd, row, col, button, color
//   out      output     out_valid / out_stall  strip_index, red_out, green_out, blue_out,
//                                              last_pixel
//   config   input      brightness_we          brightness_percent
//
// writes flow through a two-entry queue and are retired one per cycle while no scan is running
// a show scans one pixel per cycle through the frame store read port while out_stall does
// not hold the pipe, passing each pixel through the read, scale and output registers
// reset is synchronous; the frame store reads as zero until written through per-pixel valid bits
// out_stall freezes the scan pipeline in place while out_valid is high; in_stall rises only when the queue is full
module serpentine_led_frame_scaler_unit import slfs_pkg::*; #(
  parameter int MATRIX_ROWS = DefRows,
  parameter int MATRIX_COLS = DefCols
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [2:0]  row,
  input  logic [2:0]  col,
  input  logic [4:0]  button,
  input  logic [23:0] color,
  input  logic        brightness_we,
  input  logic [6:0]  brightness_percent,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  strip_index,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        last_pixel
);

  localparam int Pixels = MATRIX_ROWS * MATRIX_COLS;

  logic [PctW-1:0] brightness;
  logic            q_push;
  qent_t           q_push_ent;
  logic            q_pop;
  qent_t           q_pop_ent;
  logic            q_full;
  logic            q_not_empty;
  bk_status_t      bk_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BrightReset;
    end else if (brightness_we) begin
      brightness <= brightness_percent;
    end
  end

  slfs_front #(
    .MATRIX_ROWS(MATRIX_ROWS),
    .MATRIX_COLS(MATRIX_COLS)
  ) u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd     (cmd),
    .row     (row),
    .col     (col),
    .button  (button),
    .color   (color),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_ent   (q_push_ent)
  );

  slfs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_ent (q_push_ent),
    .pop      (q_pop),
    .pop_ent  (q_pop_ent),
    .full     (q_full),
    .not_empty(q_not_empty)
  );

  slfs_back #(
    .MATRIX_ROWS(MATRIX_ROWS),
    .MATRIX_COLS(MATRIX_COLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_not_empty(q_not_empty),
    .q_ent      (q_pop_ent),
    .q_pop      (q_pop),
    .pct_in     (brightness),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .strip_index(strip_index),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .last_pixel (last_pixel),
    .status     (bk_status)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty) else $error("queue read while empty");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_pixel) |-> (strip_index == 5'(Pixels - 1)))
    else $error("last pixel flagged away from end of strip");

  a_flag_clear_in_scan: assert property (@(posedge clk) disable iff (rst)
    bk_status.scanning |-> !bk_status.changed)
    else $error("changed flag set during a scan");

endmodule

@@ tb/sv/tb.sv @@
// testbench for the serpentine led frame scaler: predicted scan-out checked against the block
module tb;
  import slfs_pkg::*;

  localparam int ROWS   = DefRows;
  localparam int COLS   = DefCols;
  localparam int PIX    = ROWS * COLS;
  localparam int SETTLE = 40;
  localparam int HOLD   = 300;
  localparam int LIMIT  = 400000;

  typedef struct packed {
    logic [4:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_out_t;

  class frame_predictor;
    logic [23:0] frame [PIX];
    bit          dirty;
    logic [6:0]  pct_reg;
    pixel_out_t  expected_pixels [$];
    int          fails;
    int          pixels_seen;
    int          scans;

    function new();
      for (int k = 0; k < PIX; k++) frame[k] = '0;
      dirty       = 1'b0;
      pct_reg     = BrightReset;
      fails       = 0;
      pixels_seen = 0;
      scans       = 0;
    endfunction

    function void set_brightness(logic [6:0] v);
      pct_reg = v;
    endfunction

    function logic [7:0] scale(logic [7:0] ch, int pct);
      return 8'((int'(ch) * pct) / 100);
    endfunction

    // odd rows run right to left along the strip
    function bit place(int r, int c, logic [23:0] v);
      int pos;
      if (r >= ROWS || c >= COLS) return 1'b0;
      if (r % 2 == 1) pos = (r + 1) * COLS - c - 1;
      else pos = r * COLS + c;
      frame[pos] = v;
      dirty = 1'b1;
      return 1'b1;
    endfunction

    // returns 1 when the item changes state or causes pixels
    function bit note_item(cmd_t op, logic [2:0] r, logic [2:0] c, logic [4:0] btn,
                           logic [23:0] v);
      int         pct;
      bit         acted;
      pixel_out_t px;
      acted = 1'b0;
      case (op)
        CMD_WR_RC: begin
          acted = place(int'(r), int'(c), v);
        end
        CMD_WR_BTN: begin
          if (int'(btn) < PIX) acted = place(int'(btn) / COLS, int'(btn) % COLS, v);
        end
        default: begin
          if (op == CMD_SHOW_FORCED || dirty) begin
            pct = (pct_reg > PctMax) ? int'(PctMax) : int'(pct_reg);
            for (int k = 0; k < PIX; k++) begin
              px.idx   = 5'(k);
              px.red   = scale(frame[k][23:16], pct);
              px.green = scale(frame[k][15:8], pct);
              px.blue  = scale(frame[k][7:0], pct);
              px.last  = (k == PIX - 1);
              expected_pixels.push_back(px);
            end
            dirty = 1'b0;
            scans++;
            acted = 1'b1;
          end
        end
      endcase
      return acted;
    endfunction

    function void check_pixel(pixel_out_t got);
      pixel_out_t want;
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected pixel: idx=%0d r=%0d g=%0d b=%0d last=%0b",
                   got.idx, got.red, got.green, got.blue, got.last);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.idx !== want.idx || got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.last !== want.last) begin
        fails++;
        if (fails <= 10)
          $display("pixel mismatch: exp idx=%0d r=%0d g=%0d b=%0d last=%0b,",
                   want.idx, want.red, want.green, want.blue, want.last,
                   " got idx=%0d r=%0d g=%0d b=%0d last=%0b",
                   got.idx, got.red, got.green, got.blue, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cmd_t        cmd = CMD_WR_RC;
  logic [2:0]  row = '0;
  logic [2:0]  col = '0;
  logic [4:0]  button = '0;
  logic [23:0] color = '0;
  logic        brightness_we = 1'b0;
  logic [6:0]  brightness_percent = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  strip_index;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic        last_pixel;

  frame_predictor frame_pred;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int items_sent     = 0;
  int pct_settings   = 0;

  serpentine_led_frame_scaler_unit dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .cmd                (cmd),
    .row                (row),
    .col                (col),
    .button             (button),
    .color              (color),
    .brightness_we      (brightness_we),
    .brightness_percent (brightness_percent),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .strip_index        (strip_index),
    .red_out            (red_out),
    .green_out          (green_out),
    .blue_out           (blue_out),
    .last_pixel         (last_pixel)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_request != hold_seen) begin
      hold_seen <= hold_request;
      hold_left <= HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : pixel_monitor
    pixel_out_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen.idx   = strip_index;
      seen.red   = red_out;
      seen.green = green_out;
      seen.blue  = blue_out;
      seen.last  = last_pixel;
      frame_pred.check_pixel(seen);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("[serpentine_led_frame_scaler_unit] ERROR");
      $finish;
    end
  end

  task automatic send_item(cmd_t op, logic [2:0] r, logic [2:0] c, logic [4:0] btn,
                           logic [23:0] v, output bit acted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    row      <= r;
    col      <= c;
    button   <= btn;
    color    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    acted = frame_pred.note_item(op, r, c, btn, v);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frame_pred.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_brightness(logic [6:0] v);
    wait_idle();
    brightness_percent <= v;
    brightness_we      <= 1'b1;
    @(posedge clk);
    brightness_we <= 1'b0;
    frame_pred.set_brightness(v);
    pct_settings++;
  endtask

  function automatic logic [23:0] rand_color();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hffffff;
      2: return {8'hff, 16'h0000};
      3: return {8'h00, w[7:0], 8'hff};
      default: return w[23:0];
    endcase
  endfunction

  // mostly well-formed writes and shows, some out-of-range writes and noise
  task automatic send_random(output bit acted);
    cmd_t        op;
    logic [2:0]  r;
    logic [2:0]  c;
    logic [4:0]  btn;
    logic [23:0] v;
    int          sel;
    sel = $urandom_range(99);
    op  = cmd_t'($urandom_range(3));
    r   = 3'($urandom_range(7));
    c   = 3'($urandom_range(7));
    btn = 5'($urandom_range(31));
    v   = rand_color();
    if (sel < 30) begin
      op = CMD_WR_RC;
      r  = 3'($urandom_range(ROWS - 1));
      c  = 3'($urandom_range(COLS - 1));
    end else if (sel < 58) begin
      op  = CMD_WR_BTN;
      btn = 5'($urandom_range(PIX - 1));
    end else if (sel < 70) begin
      op = CMD_SHOW;
    end else if (sel < 80) begin
      op = CMD_SHOW_FORCED;
    end else if (sel < 90) begin
      if ($urandom_range(1) == 0) begin
        op = CMD_WR_RC;
        if ($urandom_range(1) == 0) r = 3'($urandom_range(7, ROWS));
        else c = 3'($urandom_range(7, COLS));
      end else begin
        op  = CMD_WR_BTN;
        btn = 5'($urandom_range(31, PIX));
      end
    end
    send_item(op, r, c, btn, v, acted);
  endtask

  task automatic run_phase(int n, int sidle, int rstall, logic [6:0] pct, bit pressure);
    int done;
    bit acted;
    write_brightness(pct);
    send_idle_pct  = sidle;
    recv_stall_pct <= rstall;
    if (pressure) hold_request <= hold_request + 1;
    done = 0;
    while (done < n) begin
      send_random(acted);
      if (acted) done++;
    end
    wait_idle();
  endtask

  initial begin
    bit acted;
    frame_pred = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: cleared store, serpentine corners, bad positions, show rules
    send_item(CMD_SHOW, 3'd0, 3'd0, 5'd0, 24'h000000, acted);
    send_item(CMD_SHOW_FORCED, 3'd7, 3'd7, 5'd31, 24'hffffff, acted);
    send_item(CMD_WR_RC, 3'd0, 3'd0, 5'd0, 24'hffffff, acted);
    send_item(CMD_WR_RC, 3'd4, 3'd4, 5'd31, 24'h808080, acted);
    send_item(CMD_WR_RC, 3'd1, 3'd0, 5'd0, 24'hff0000, acted);
    send_item(CMD_WR_RC, 3'd3, 3'd4, 5'd0, 24'h00ff00, acted);
    send_item(CMD_WR_BTN, 3'd7, 3'd7, 5'd0, 24'h0000ff, acted);
    send_item(CMD_WR_BTN, 3'd7, 3'd7, 5'd24, 24'hfedcba, acted);
    send_item(CMD_WR_BTN, 3'd0, 3'd0, 5'd7, 24'h123456, acted);
    send_item(CMD_WR_RC, 3'd5, 3'd0, 5'd0, 24'hffffff, acted);
    send_item(CMD_WR_RC, 3'd7, 3'd7, 5'd0, 24'hffffff, acted);
    send_item(CMD_WR_RC, 3'd0, 3'd5, 5'd0, 24'hffffff, acted);
    send_item(CMD_WR_BTN, 3'd0, 3'd0, 5'd25, 24'hffffff, acted);
    send_item(CMD_WR_BTN, 3'd0, 3'd0, 5'd31, 24'hffffff, acted);
    send_item(CMD_SHOW, 3'd0, 3'd0, 5'd0, 24'h000000, acted);
    send_item(CMD_SHOW, 3'd0, 3'd0, 5'd0, 24'h000000, acted);
    send_item(CMD_SHOW_FORCED, 3'd0, 3'd0, 5'd0, 24'h000000, acted);
    write_brightness(PctMax);
    send_item(CMD_SHOW_FORCED, 3'd0, 3'd0, 5'd0, 24'h000000, acted);
    write_brightness(7'd127);
    send_item(CMD_SHOW_FORCED, 3'd0, 3'd0, 5'd0, 24'h000000, acted);
    write_brightness(7'd0);
    send_item(CMD_SHOW_FORCED, 3'd0, 3'd0, 5'd0, 24'h000000, acted);
    write_brightness(7'd1);
    send_item(CMD_WR_RC, 3'd2, 3'd2, 5'd0, 24'hffffff, acted);
    send_item(CMD_SHOW, 3'd0, 3'd0, 5'd0, 24'h000000, acted);

    run_phase(45, 0, 0, 7'($urandom_range(127)), 1'b0);
    run_phase(25, 0, 0, 7'd100, 1'b1);
    run_phase(40, 80, 0, 7'($urandom_range(127)), 1'b0);
    run_phase(40, 0, 80, 7'($urandom_range(100)), 1'b0);
    run_phase(45, 34, 34, 7'd101, 1'b0);

    $display("covered %0d items, %0d scans, %0d pixels checked, %0d brightness settings",
             items_sent, frame_pred.scans, frame_pred.pixels_seen, pct_settings);
    $display("idle modes: none, long receiver hold-off, sender gaps, receiver stalls, both");
    if (frame_pred.fails == 0 && frame_pred.expected_pixels.size() == 0) begin
      $display("[serpentine_led_frame_scaler_unit] OK");
    end else begin
      $display("%0d mismatches, %0d pixels never seen", frame_pred.fails,
               frame_pred.expected_pixels.size());
      $display("[serpentine_led_frame_scaler_unit] ERROR");
    end
    $finish;
  end

endmodule
